/* hw/rtl/clpm_pkg.sv */
// Shared types, constants and frame byte functions of the console link presence monitor.
`timescale 1ns / 1ps

package clpm_pkg;

	// Width of the tick age counter; the age saturates at all ones.
	localparam int TICK_COUNT_BITS = 16;
	localparam int TIMEOUT_BITS    = 16;
	localparam int AGE_CMP_W       = (TICK_COUNT_BITS > TIMEOUT_BITS) ? TICK_COUNT_BITS
	                                                                  : TIMEOUT_BITS;
	localparam logic [TICK_COUNT_BITS-1:0] AGE_MAX = {TICK_COUNT_BITS{1'b1}};

	// Receive side limits.
	localparam logic [5:0] RX_POS_MAX = 6'd63;
	localparam logic [5:0] RX_MIN_LEN = 6'd24;

	// Emitted frame geometry.
	localparam int         BEACON_BYTES   = 52;
	localparam logic [5:0] FRAME_LAST_IDX = 6'(BEACON_BYTES - 1);

	// Addresses and protocol constants.
	localparam logic [47:0] FIXED_CONSOLE  = 48'h0004_C408_C854;
	localparam logic [23:0] CONSOLE_OUI    = 24'h0004C4;
	localparam logic [7:0]  ETYPE_HI       = 8'h04;
	localparam logic [7:0]  ETYPE_LO       = 8'hEE;
	localparam logic [7:0]  TYPE_ANNOUNCE  = 8'hF0;
	localparam logic [7:0]  TYPE_HEARTBEAT = 8'hF1;

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_START = 2'd2,
		KIND_STOP  = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_OWN_ADDR      = 3'd0,
		CFG_CHANS         = 3'd1,
		CFG_RATE          = 3'd2,
		CFG_INTERVAL      = 3'd3,
		CFG_TIMEOUT       = 3'd4,
		CFG_SEND_ANNOUNCE = 3'd5
	} cfg_idx_t;

	// Link state machine, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE       = 4'b0001,
		ST_ANNOUNCING = 4'b0010,
		ST_CONNECTED  = 4'b0100,
		ST_LOST       = 4'b1000
	} link_st_t;

	// Link state codes as reported on the result channel.
	localparam logic [1:0] LINK_IDLE       = 2'd0;
	localparam logic [1:0] LINK_ANNOUNCING = 2'd1;
	localparam logic [1:0] LINK_CONNECTED  = 2'd2;
	localparam logic [1:0] LINK_LOST       = 2'd3;

	// Verdict of the receive filter for the byte being accepted.
	typedef struct packed {
		logic        hit;
		logic [47:0] source;
	} rx_verdict_t;

	// Everything the output stage needs to deliver the results of one item.
	typedef struct packed {
		logic        frame;
		logic        hb;
		logic [4:0]  seq;
		logic [1:0]  link_state;
		logic        changed;
		logic [47:0] addr;
		logic        known;
	} tx_job_t;

	// Encode the one-hot state into its reported code.
	function automatic logic [1:0] link_code(input link_st_t s);
		logic [1:0] code;
		unique case (s)
			ST_IDLE:       code = LINK_IDLE;
			ST_ANNOUNCING: code = LINK_ANNOUNCING;
			ST_CONNECTED:  code = LINK_CONNECTED;
			ST_LOST:       code = LINK_LOST;
			default:       code = LINK_IDLE;
		endcase
		return code;
	endfunction

	// Expected console header byte at receive offsets 14 to 18.
	function automatic logic [7:0] hdr_expect(input logic [5:0] pos);
		logic [7:0] b;
		case (pos)
			6'd16:   b = 8'h04;
			6'd17:   b = 8'hEA;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// Byte of the announce or heartbeat frame at a given offset.
	function automatic logic [7:0] tx_byte(
		input logic [5:0]  idx,
		input logic        hb,
		input logic [4:0]  seq,
		input logic [47:0] mac,
		input logic [15:0] chans,
		input logic [31:0] rate
	);
		logic [7:0] b;
		case (idx) inside
			[6'd0:6'd5]: b = 8'hFF;
			6'd6:        b = mac[47:40];
			6'd7:        b = mac[39:32];
			6'd8:        b = mac[31:24];
			6'd9:        b = mac[23:16];
			6'd10:       b = mac[15:8];
			6'd11:       b = mac[7:0];
			6'd12:       b = ETYPE_HI;
			6'd13:       b = ETYPE_LO;
			6'd19:       b = {3'b000, seq};
			6'd20:       b = hb ? TYPE_HEARTBEAT : TYPE_ANNOUNCE;
			6'd24:       b = 8'h47;
			6'd25:       b = 8'h41;
			6'd26:       b = 8'h43;
			6'd27:       b = 8'h45;
			6'd28:       b = hb ? 8'h02 : 8'h01;
			6'd29:       b = 8'h48;
			6'd30:       b = chans[15:8];
			6'd31:       b = chans[7:0];
			6'd32:       b = rate[31:24];
			6'd33:       b = rate[23:16];
			6'd34:       b = rate[15:8];
			6'd35:       b = rate[7:0];
			6'd36:       b = 8'h47;
			6'd37:       b = 8'h58;
			6'd38:       b = 8'h34;
			6'd39:       b = 8'h38;
			6'd40:       b = 8'h31;
			6'd41:       b = 8'h36;
			default:     b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/clpm_intf.sv */
// Valid/ready channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps

interface clpm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source(output valid, kind, frame_byte, frame_last, input ready);
	modport sink(input valid, kind, frame_byte, frame_last, output ready);
endinterface

interface clpm_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic [1:0]  link_state;
	logic        state_changed;
	logic [47:0] console_addr;
	logic        console_known;

	modport source(output valid, out_byte, byte_valid, last, link_state, state_changed,
		console_addr, console_known, input ready);
	modport sink(input valid, out_byte, byte_valid, last, link_state, state_changed,
		console_addr, console_known, output ready);
endinterface

interface clpm_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/clpm_rx.sv */
// Receive filter: tracks the frame being received and judges it on its last byte.
`timescale 1ns / 1ps

module clpm_rx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	input  logic                 rx_last,
	input  logic [47:0]          own_addr,
	output clpm_pkg::rx_verdict_t verdict
);
	import clpm_pkg::*;

	logic [5:0]  pos_q;
	logic [47:0] src_q;
	logic [1:0]  flags_q;

	logic [5:0]  len;
	logic [47:0] src_n;
	logic [1:0]  flags_n;
	logic        type_bad;
	logic        hdr_bad;
	logic        from_fixed;
	logic        from_oui;
	logic        from_local;

	// Byte count so far, including this byte, saturating.
	assign len = (pos_q == RX_POS_MAX) ? RX_POS_MAX : pos_q + 6'd1;

	// Source address collects bytes 6 to 11.
	assign src_n = (pos_q >= 6'd6 && pos_q <= 6'd11) ? {src_q[39:0], rx_byte} : src_q;

	// EtherType and console header checks.
	assign type_bad = (pos_q == 6'd12 && rx_byte != ETYPE_HI)
		|| (pos_q == 6'd13 && rx_byte != ETYPE_LO);
	assign hdr_bad  = (pos_q >= 6'd14 && pos_q <= 6'd18) && (rx_byte != hdr_expect(pos_q));
	assign flags_n  = {flags_q[1] & ~hdr_bad, flags_q[0] & ~type_bad};

	// Frame verdict on the final byte.
	assign from_fixed = (src_n == FIXED_CONSOLE);
	assign from_oui   = (src_n[47:24] == CONSOLE_OUI);
	assign from_local = (src_n == own_addr);

	assign verdict.hit = byte_en && rx_last && (len >= RX_MIN_LEN) && flags_n[0]
		&& (from_fixed || (from_oui && flags_n[1] && !from_local));
	assign verdict.source = src_n;

	// Receive tracking registers; the last byte rearms them for the next frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			src_q   <= '0;
			flags_q <= 2'b11;
		end else if (byte_en) begin
			if (rx_last) begin
				pos_q   <= '0;
				src_q   <= '0;
				flags_q <= 2'b11;
			end else begin
				pos_q   <= len;
				src_q   <= src_n;
				flags_q <= flags_n;
			end
		end
	end

	// Checks are only ever cleared from the EtherType offset on.
	a_flags_early: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q < 6'd12) |-> (flags_q == 2'b11))
		else $error("receive checks cleared before the EtherType");

	// A fresh frame starts with an empty source.
	a_src_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= 6'd6) |-> (src_q == '0))
		else $error("source not empty at frame start");

endmodule

/* hw/rtl/clpm_tx.sv */
// Result stage: holds the results of one item and streams announce or heartbeat frame bytes.
`timescale 1ns / 1ps

module clpm_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  clpm_pkg::tx_job_t job,
	input  logic [47:0]       own_addr,
	input  logic [15:0]       chans,
	input  logic [31:0]       rate,
	output logic              free,
	clpm_out_if.source        result
);
	import clpm_pkg::*;

	logic       valid_q;
	logic [5:0] idx_q;
	tx_job_t    job_q;

	logic last_w;
	logic xfer;
	logic done;

	// Last result of the item: end of the frame, or the single status result.
	assign last_w = job_q.frame ? (idx_q == FRAME_LAST_IDX) : 1'b1;
	assign xfer   = valid_q && result.ready;
	assign done   = xfer && last_w;
	assign free   = !valid_q || done;

	// Result channel payload.
	assign result.valid         = valid_q;
	assign result.out_byte      = job_q.frame
		? tx_byte(idx_q, job_q.hb, job_q.seq, own_addr, chans, rate) : 8'h00;
	assign result.byte_valid    = job_q.frame;
	assign result.last          = last_w;
	assign result.link_state    = job_q.link_state;
	assign result.state_changed = job_q.changed;
	assign result.console_addr  = job_q.addr;
	assign result.console_known = job_q.known;

	// Occupancy and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (xfer) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	// Job payload.
	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
	end

	// The byte index stays inside the frame.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && job_q.frame) |-> (idx_q <= FRAME_LAST_IDX))
		else $error("frame byte index out of range");

	// A status-only result never advances the index.
	a_idx_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !job_q.frame) |-> (idx_q == '0))
		else $error("index moved on a status-only result");

endmodule

/* hw/rtl/console_link_presence_monitor.sv */
// Top level of the console link presence monitor: configuration, link state and timers.
`timescale 1ns / 1ps

// Usage:
//   item   - input items: a received frame byte (with frame_last on its final byte),
//            a one millisecond tick, start or stop.
//   cfg    - register writes by index; always ready. Write only while the block is idle.
//   result - result items. An item that emits no frame gives one status result; an
//            item that triggers an announce or heartbeat gives 52 results, one frame
//            byte each, with last on the final one. Every result carries the link
//            state, the state change flag and the captured console address.
// Result timing: the first result of an item is offered in the cycle after its transfer.
// Throughput: one item per cycle while items give a single result each and result
//   ready is high. An item that emits a frame holds the result register for 52
//   transfers; the byte serializer in the result stage sets this, and the next item
//   is taken in the cycle that the last frame byte transfers.
// Reset: link state idle, not running, no console known, counters cleared, the
//   registers at their defaults (sample rate 48000, interval 100, timeout 1000).
// Stall: while the receiver holds ready low the pending result stays and item
//   ready stays low; no state moves.
module console_link_presence_monitor (
	input  logic        clk,
	input  logic        arst_n,
	clpm_in_if.sink     item,
	clpm_cfg_if.sink    cfg,
	clpm_out_if.source  result
);
	import clpm_pkg::*;

	// Configuration registers.
	logic [47:0] own_addr_q;
	logic [15:0] chans_q;
	logic [31:0] rate_q;
	logic [15:0] interval_q;
	logic [15:0] timeout_q;
	logic        send_q;

	// Link control state.
	link_st_t                   st_q;
	logic                       run_q;
	logic                       seen_q;
	logic [47:0]                cons_q;
	logic [TICK_COUNT_BITS-1:0] age_q;
	logic [15:0]                left_q;
	logic [4:0]                 seq_q;

	// Next-state values.
	link_st_t                   st_n;
	logic                       run_n;
	logic                       seen_n;
	logic [47:0]                cons_n;
	logic [TICK_COUNT_BITS-1:0] age_n;
	logic [15:0]                left_n;
	logic [4:0]                 seq_n;
	logic                       iter;
	logic                       live;
	tx_job_t                    job;

	logic        take;
	logic        tx_free;
	kind_t       kind_w;
	rx_verdict_t verdict;

	assign cfg.ready  = 1'b1;
	assign item.ready = tx_free;
	assign take       = item.valid && item.ready;
	assign kind_w     = kind_t'(item.kind);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			chans_q    <= '0;
			rate_q     <= 32'd48000;
			interval_q <= 16'd100;
			timeout_q  <= 16'd1000;
			send_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_OWN_ADDR:      own_addr_q <= cfg.data;
				CFG_CHANS:         chans_q    <= cfg.data[15:0];
				CFG_RATE:          rate_q     <= cfg.data[31:0];
				CFG_INTERVAL:      interval_q <= cfg.data[15:0];
				CFG_TIMEOUT:       timeout_q  <= cfg.data[15:0];
				CFG_SEND_ANNOUNCE: send_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Receive filter.
	clpm_rx u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (take && (kind_w == KIND_BYTE)),
		.rx_byte (item.frame_byte),
		.rx_last (item.frame_last),
		.own_addr(own_addr_q),
		.verdict (verdict)
	);

	// Item handling, then one announce and state check iteration when due.
	always_comb begin
		st_n   = st_q;
		run_n  = run_q;
		seen_n = seen_q;
		cons_n = cons_q;
		age_n  = age_q;
		left_n = left_q;
		seq_n  = seq_q;
		iter   = 1'b0;

		case (kind_w)
			KIND_BYTE: begin
				if (verdict.hit) begin
					if (!seen_q) begin
						cons_n = verdict.source;
					end
					seen_n = 1'b1;
					age_n  = '0;
				end
			end
			KIND_TICK: begin
				if (age_q != AGE_MAX) begin
					age_n = age_q + TICK_COUNT_BITS'(1);
				end
				if (run_q) begin
					if (left_q > 16'd1) begin
						left_n = left_q - 16'd1;
					end else begin
						iter = 1'b1;
					end
				end
			end
			KIND_START: begin
				if (!run_q) begin
					run_n  = 1'b1;
					seen_n = 1'b0;
					seq_n  = '0;
					st_n   = ST_ANNOUNCING;
					iter   = 1'b1;
				end
			end
			KIND_STOP: begin
				if (run_q) begin
					run_n = 1'b0;
					st_n  = ST_IDLE;
				end
			end
			default: ;
		endcase

		job.frame = iter && send_q;
		job.hb    = (st_n == ST_CONNECTED);
		job.seq   = seq_n;
		live      = seen_n && (AGE_CMP_W'(age_n) < AGE_CMP_W'(timeout_q));

		if (iter) begin
			if (send_q) begin
				seq_n = seq_n + 5'd1;
			end
			if (live && st_n != ST_CONNECTED) begin
				st_n = ST_CONNECTED;
			end else if (!live && st_n == ST_CONNECTED) begin
				st_n = ST_LOST;
			end
			left_n = (interval_q == '0) ? 16'd1 : interval_q;
		end

		job.link_state = link_code(st_n);
		job.changed    = (st_n != st_q);
		job.addr       = seen_n ? cons_n : '0;
		job.known      = seen_n;
	end

	// Link control registers advance on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			run_q  <= 1'b0;
			seen_q <= 1'b0;
			cons_q <= '0;
			age_q  <= '0;
			left_q <= '0;
			seq_q  <= '0;
		end else if (take) begin
			st_q   <= st_n;
			run_q  <= run_n;
			seen_q <= seen_n;
			cons_q <= cons_n;
			age_q  <= age_n;
			left_q <= left_n;
			seq_q  <= seq_n;
		end
	end

	// Result stage.
	clpm_tx u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (take),
		.job     (job),
		.own_addr(own_addr_q),
		.chans   (chans_q),
		.rate    (rate_q),
		.free    (tx_free),
		.result  (result)
	);

	// The link reads idle exactly while the block is stopped.
	a_idle_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) == !run_q)
		else $error("link state and running flag disagree");

	// No console address is reported before one is known.
	a_addr_known: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.console_known) |-> (result.console_addr == '0))
		else $error("console address shown while unknown");

endmodule
